// ----- hdl/ftbg_pkg.sv -----
// ----------------------------------------------------------------------------
// ftbg_pkg: shared types and constants of the frame time budget governor
// Item layouts, register indexes, reset values and result codes.
// ----------------------------------------------------------------------------
package ftbg_pkg;

  // width of the saturating reduction and increase totals
  localparam int StatCountWidth = 32;

  localparam int CfgIndexWidth = 4;
  localparam int CfgDataWidth  = 16;

  // register reset values
  localparam logic        EnableReset           = 1'b1;
  localparam logic [15:0] BudgetMaxReset        = 16'd1000;
  localparam logic [15:0] StressThresholdReset  = 16'd5120;
  localparam logic [15:0] TargetFrameTimeReset  = 16'd4250;
  localparam logic [15:0] StableRequiredReset   = 16'd60;
  localparam logic [15:0] UnstableRequiredReset = 16'd10;
  localparam logic [15:0] StepDownReset         = 16'd5;
  localparam logic [15:0] StepUpReset           = 16'd1;

  // 16.6 ms in q8.8
  localparam logic [15:0] AvgReset = 16'd4250;
  // lowest floor of the budget
  localparam logic [15:0] FloorMin = 16'd50;
  // weight of a new sample, 0.05 in q0.16; old weight is 65536 minus this
  localparam logic [11:0] AvgWeightNew = 12'd3277;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_ENABLE            = 4'd0,
    REG_BUDGET_MAX        = 4'd1,
    REG_STRESS_THRESHOLD  = 4'd2,
    REG_TARGET_FRAME_TIME = 4'd3,
    REG_STABLE_REQUIRED   = 4'd4,
    REG_UNSTABLE_REQUIRED = 4'd5,
    REG_STEP_DOWN         = 4'd6,
    REG_STEP_UP           = 4'd7
  } reg_index_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ADJ_NONE = 2'd0,
    ADJ_DOWN = 2'd1,
    ADJ_UP   = 2'd2
  } adjustment_t;

  typedef struct packed {
    logic        command;
    logic [15:0] frame_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] budget;
    logic [15:0] avg_frame_time;
    logic        stressed;
    logic [1:0]  adjustment;
    logic [15:0] stable_run;
    logic [15:0] unstable_run;
    logic [31:0] reduction_count;
    logic [31:0] increase_count;
  } out_item_t;

endpackage

// ----- hdl/ftbg_if.sv -----
// ----------------------------------------------------------------------------
// ftbg channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface ftbg_in_if import ftbg_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftbg_out_if import ftbg_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftbg_cfg_if import ftbg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- hdl/frame_time_budget_governor_core.sv -----
// ----------------------------------------------------------------------------
// frame_time_budget_governor_core
// Tracks a moving average of frame times and steps a workload budget.
// ----------------------------------------------------------------------------
//
// channel   direction  payload                         handshake
// sample    in         command, frame_time             valid/ready
// result    out        budget, average, runs, totals   valid/ready
// cfg       in         register index, write data      valid/ready, always ready
//
// one item per cycle sustained while the result is taken; an accepted sample passes
// through the input register and the compute stage into the result register
// all state updates happen in the single compute stage after the input register
// synchronous reset restores register defaults, sets budget to its reset maximum and clears statistics
// a stalled result holds the compute stage; sample ready drops only when both
// the input register and the result register are full and result is not taken
//
module frame_time_budget_governor_core import ftbg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ftbg_in_if.sink     sample,
  ftbg_out_if.source  result,
  ftbg_cfg_if.sink    cfg
);

  // configuration registers
  logic        enable;
  logic [15:0] budget_max;
  logic [15:0] stress_limit;
  logic [15:0] target_time;
  logic [15:0] stable_required;
  logic [15:0] unstable_required;
  logic [15:0] step_down;
  logic [15:0] step_up;

  // governor state
  logic [15:0]               budget_now;
  logic [15:0]               average_time;
  logic [15:0]               stable_counter;
  logic [15:0]               unstable_counter;
  logic [StatCountWidth-1:0] reductions_total;
  logic [StatCountWidth-1:0] increases_total;

  logic [15:0]               budget_now_next;
  logic [15:0]               average_time_next;
  logic [15:0]               stable_counter_next;
  logic [15:0]               unstable_counter_next;
  logic [StatCountWidth-1:0] reductions_total_next;
  logic [StatCountWidth-1:0] increases_total_next;
  adjustment_t               adj;

  // pipeline registers
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_adv;
  logic      s1_fire;
  logic      out_valid;
  out_item_t out_data;

  // moving average datapath
  logic signed [16:0] avg_diff;
  logic signed [29:0] avg_prod;
  logic signed [33:0] avg_acc;
  logic [15:0]        avg_new;

  // step decision
  logic [15:0] run_up;
  logic [15:0] run_down;
  logic [15:0] half_max;
  logic [15:0] floor_v;
  logic [16:0] floor_plus_step;
  logic [16:0] raised;
  logic        is_stressed;
  logic        is_stable;

  function automatic logic [15:0] run_inc(input logic [15:0] v);
    run_inc = (&v) ? v : v + 16'd1;
  endfunction

  function automatic logic [StatCountWidth-1:0] stat_inc(input logic [StatCountWidth-1:0] v);
    stat_inc = (&v) ? v : v + StatCountWidth'(1);
  endfunction

  // handshakes
  assign cfg.ready    = 1'b1;
  assign s1_adv       = !out_valid || result.ready;
  assign s1_fire      = s1_valid && s1_adv;
  assign sample.ready = !s1_valid || s1_adv;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // avg*(65536-w) + t*w = (avg << 16) + w*(t - avg), one multiply
  assign avg_diff = $signed({1'b0, s1_item.frame_time}) - $signed({1'b0, average_time});
  assign avg_prod = avg_diff * $signed({1'b0, AvgWeightNew});
  assign avg_acc  = $signed({2'b00, average_time, 16'h0000}) + 34'(avg_prod)
                    + 34'sd32768;
  assign avg_new  = avg_acc[31:16];

  assign is_stressed = s1_item.frame_time > stress_limit;
  assign is_stable   = s1_item.frame_time < target_time;
  assign run_up      = run_inc(stable_counter);
  assign run_down    = run_inc(unstable_counter);

  // floor is max(50, budget_max/2); step down only if budget - step >= floor
  assign half_max        = {1'b0, budget_max[15:1]};
  assign floor_v         = (half_max < FloorMin) ? FloorMin : half_max;
  assign floor_plus_step = {1'b0, floor_v} + {1'b0, step_down};
  assign raised          = {1'b0, budget_now} + {1'b0, step_up};

  always_comb begin
    budget_now_next       = budget_now;
    average_time_next     = average_time;
    stable_counter_next   = stable_counter;
    unstable_counter_next = unstable_counter;
    reductions_total_next = reductions_total;
    increases_total_next  = increases_total;
    adj                   = ADJ_NONE;
    if (s1_item.command == CMD_CLEAR) begin
      budget_now_next       = budget_max;
      average_time_next     = AvgReset;
      stable_counter_next   = '0;
      unstable_counter_next = '0;
      reductions_total_next = '0;
      increases_total_next  = '0;
    end else if (enable) begin
      average_time_next = avg_new;
      if (is_stressed) begin
        unstable_counter_next = run_down;
        stable_counter_next   = '0;
        if (run_down >= unstable_required && {1'b0, budget_now} >= floor_plus_step) begin
          budget_now_next       = budget_now - step_down;
          reductions_total_next = stat_inc(reductions_total);
          unstable_counter_next = '0;
          adj                   = ADJ_DOWN;
        end
      end else if (is_stable) begin
        stable_counter_next   = run_up;
        unstable_counter_next = '0;
        if (run_up >= stable_required && raised <= {1'b0, budget_max}) begin
          budget_now_next      = raised[15:0];
          increases_total_next = stat_inc(increases_total);
          stable_counter_next  = '0;
          adj                  = ADJ_UP;
        end
      end else begin
        stable_counter_next   = '0;
        unstable_counter_next = '0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable            <= EnableReset;
      budget_max        <= BudgetMaxReset;
      stress_limit      <= StressThresholdReset;
      target_time       <= TargetFrameTimeReset;
      stable_required   <= StableRequiredReset;
      unstable_required <= UnstableRequiredReset;
      step_down         <= StepDownReset;
      step_up           <= StepUpReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ENABLE:            enable            <= cfg.wdata[0];
        REG_BUDGET_MAX:        budget_max        <= cfg.wdata;
        REG_STRESS_THRESHOLD:  stress_limit      <= cfg.wdata;
        REG_TARGET_FRAME_TIME: target_time       <= cfg.wdata;
        REG_STABLE_REQUIRED:   stable_required   <= cfg.wdata;
        REG_UNSTABLE_REQUIRED: unstable_required <= cfg.wdata;
        REG_STEP_DOWN:         step_down         <= cfg.wdata;
        REG_STEP_UP:           step_up           <= cfg.wdata;
        default:               ;
      endcase
    end
  end

  // state, input register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      budget_now       <= BudgetMaxReset;
      average_time     <= AvgReset;
      stable_counter   <= '0;
      unstable_counter <= '0;
      reductions_total <= '0;
      increases_total  <= '0;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (sample.valid && sample.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        budget_now       <= budget_now_next;
        average_time     <= average_time_next;
        stable_counter   <= stable_counter_next;
        unstable_counter <= unstable_counter_next;
        reductions_total <= reductions_total_next;
        increases_total  <= increases_total_next;
        out_valid        <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_item <= sample.data;
    end
    if (s1_fire) begin
      out_data.budget          <= budget_now_next;
      out_data.avg_frame_time  <= average_time_next;
      out_data.stressed        <= average_time_next > stress_limit;
      out_data.adjustment      <= adj;
      out_data.stable_run      <= stable_counter_next;
      out_data.unstable_run    <= unstable_counter_next;
      out_data.reduction_count <= 32'(reductions_total_next);
      out_data.increase_count  <= 32'(increases_total_next);
    end
  end

  // a finished stage always lands in the result register
  a_fire_to_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("compute stage fired but result register is empty");

  // only one run counter can be nonzero at a time
  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.stable_run == 16'd0 || out_data.unstable_run == 16'd0))
    else $error("both run counters nonzero");

  // a step clears both runs
  a_step_clears_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.adjustment != ADJ_NONE
      |-> (out_data.stable_run == 16'd0 && out_data.unstable_run == 16'd0))
    else $error("run counter not cleared after a budget step");

  // a clear command yields the default average and no adjustment
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_item.command == CMD_CLEAR
      |=> (out_data.avg_frame_time == AvgReset && out_data.adjustment == ADJ_NONE))
    else $error("clear command did not restore defaults");

  // a held result keeps the compute stage from overwriting it
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
